### hw/rtl/afl_pkg.sv
// Shared types, constants, sine table and microprogram of the audio flanger.
package afl_pkg;

   localparam int LINE_ENTRIES_DEF = 2048;

   localparam int SAMPLE_W   = 16;
   localparam int LEN_CFG_W  = 12;
   localparam int OFFSET_W   = 11;
   localparam int DEPTH_W    = 11;
   localparam int PHASE_W    = 31;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_OFFSET  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD_DEPTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYPASS      = 3'd4;

   localparam logic [LEN_CFG_W-1:0] LINE_LENGTH_RST = 12'd2048;

   localparam logic [SAMPLE_W-1:0] SAMPLE_POS_MAX = 16'h7fff;
   localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_MAX = 16'h8000;

   typedef struct packed {
      logic [LEN_CFG_W-1:0] line_length;
      logic [OFFSET_W-1:0]  tap_offset;
      logic [DEPTH_W-1:0]   mod_depth;
      logic [PHASE_W-1:0]   phase_step;
      logic                 bypass;
   } afl_cfg_type;

   // ---------------------------------------------------------------- microcode
   localparam int STEP_W = 4;

   localparam logic [STEP_W-1:0] STEP_CLR  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_IDLE = 4'd1;
   localparam logic [STEP_W-1:0] STEP_SIN0 = 4'd2;
   localparam logic [STEP_W-1:0] STEP_SIN1 = 4'd3;
   localparam logic [STEP_W-1:0] STEP_SN   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MDEP = 4'd5;
   localparam logic [STEP_W-1:0] STEP_RAW  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DIV  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_NEAR = 4'd8;
   localparam logic [STEP_W-1:0] STEP_FAR  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_LDA  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_DIFF = 4'd11;
   localparam logic [STEP_W-1:0] STEP_MINT = 4'd12;
   localparam logic [STEP_W-1:0] STEP_SUM  = 4'd13;
   localparam logic [STEP_W-1:0] STEP_PASS = 4'd14;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SIN0,
      MUL_SIN1,
      MUL_DEPTH,
      MUL_INTERP
   } afl_mul_type;

   typedef enum logic [3:0] {
      ALU_NOP,
      ALU_CLR,
      ALU_S1,
      ALU_SN,
      ALU_RAW,
      ALU_DIV,
      ALU_NEAR,
      ALU_FAR,
      ALU_LDA,
      ALU_DIFF,
      ALU_SUM,
      ALU_PASS
   } afl_alu_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_BYPASS,
      COND_DIV_MORE,
      COND_CLR_MORE,
      COND_OUT_BUSY
   } afl_cond_type;

   typedef struct packed {
      logic              take;
      logic              rd_far;
      afl_mul_type       mul;
      afl_alu_type       alu;
      afl_cond_type      cond;
      logic [STEP_W-1:0] target;
   } afl_ctrl_type;

   typedef struct packed {
      logic req_fire;
      logic bypass;
      logic div_more;
      logic clr_more;
      logic out_busy;
   } afl_status_type;

   function automatic afl_ctrl_type uc_word(logic take, logic rd_far, afl_mul_type mul,
                                            afl_alu_type alu, afl_cond_type cond,
                                            logic [STEP_W-1:0] target);
      afl_ctrl_type w;
      w.take   = take;
      w.rd_far = rd_far;
      w.mul    = mul;
      w.alu    = alu;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   function automatic afl_ctrl_type afl_ucode(logic [STEP_W-1:0] step);
      unique case (step)
         STEP_CLR:  return uc_word(1'b0, 1'b0, MUL_NONE,   ALU_CLR,  COND_CLR_MORE, STEP_CLR);
         STEP_IDLE: return uc_word(1'b1, 1'b0, MUL_NONE,   ALU_NOP,  COND_NO_REQ,   STEP_IDLE);
         STEP_SIN0: return uc_word(1'b0, 1'b0, MUL_SIN0,   ALU_NOP,  COND_BYPASS,   STEP_PASS);
         STEP_SIN1: return uc_word(1'b0, 1'b0, MUL_SIN1,   ALU_S1,   COND_NONE,     STEP_IDLE);
         STEP_SN:   return uc_word(1'b0, 1'b0, MUL_NONE,   ALU_SN,   COND_NONE,     STEP_IDLE);
         STEP_MDEP: return uc_word(1'b0, 1'b0, MUL_DEPTH,  ALU_NOP,  COND_NONE,     STEP_IDLE);
         STEP_RAW:  return uc_word(1'b0, 1'b0, MUL_NONE,   ALU_RAW,  COND_NONE,     STEP_IDLE);
         STEP_DIV:  return uc_word(1'b0, 1'b0, MUL_NONE,   ALU_DIV,  COND_DIV_MORE, STEP_DIV);
         STEP_NEAR: return uc_word(1'b0, 1'b0, MUL_NONE,   ALU_NEAR, COND_NONE,     STEP_IDLE);
         STEP_FAR:  return uc_word(1'b0, 1'b0, MUL_NONE,   ALU_FAR,  COND_NONE,     STEP_IDLE);
         STEP_LDA:  return uc_word(1'b0, 1'b1, MUL_NONE,   ALU_LDA,  COND_NONE,     STEP_IDLE);
         STEP_DIFF: return uc_word(1'b0, 1'b0, MUL_NONE,   ALU_DIFF, COND_NONE,     STEP_IDLE);
         STEP_MINT: return uc_word(1'b0, 1'b0, MUL_INTERP, ALU_NOP,  COND_NONE,     STEP_IDLE);
         STEP_SUM:  return uc_word(1'b0, 1'b0, MUL_NONE,   ALU_SUM,  COND_OUT_BUSY, STEP_IDLE);
         STEP_PASS: return uc_word(1'b0, 1'b0, MUL_NONE,   ALU_PASS, COND_OUT_BUSY, STEP_IDLE);
         default:   return uc_word(1'b0, 1'b0, MUL_NONE,   ALU_NOP,  COND_ALWAYS,   STEP_IDLE);
      endcase
   endfunction

   // ---------------------------------------------------------------- sine table
   // Quarter wave, Q15, entries for n*pi/256 with n = 0..128, built by a Taylor
   // series in Q28 while the design elaborates.
   localparam int QSINE_LAST = 128;

   typedef logic [14:0] qsine_tab_type [0:QSINE_LAST];

   localparam longint unsigned SER_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210, 64'd272};

   function automatic qsine_tab_type build_qsine();
      qsine_tab_type  tab;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          q;
      for (int n = 0; n <= QSINE_LAST; n++) begin
         x    = (64'(n) * 64'd843314857 + 64'd128) >> 8;
         x2   = (x * x) >> 28;
         term = x;
         sum  = longint'(x);
         for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 28) / SER_DIV[k];
            if ((k % 2) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         q = (sum + 64'sd4096) >>> 13;
         if (q > 32767) begin
            q = 32767;
         end
         tab[n] = 15'(q);
      end
      return tab;
   endfunction

   localparam qsine_tab_type QSINE = build_qsine();

   // Full wave entry n = 0..512 folded onto the quarter table.
   function automatic logic signed [15:0] sine_entry(logic [9:0] n);
      logic [9:0] m;
      logic       neg;
      logic [7:0] qi;
      priority if (n <= 10'd128) begin
         m   = n;
         neg = 1'b0;
      end else if (n <= 10'd256) begin
         m   = 10'd256 - n;
         neg = 1'b0;
      end else if (n <= 10'd384) begin
         m   = n - 10'd256;
         neg = 1'b1;
      end else begin
         m   = 10'd512 - n;
         neg = 1'b1;
      end
      qi = m[7:0];
      if (neg) begin
         return -$signed({1'b0, QSINE[qi]});
      end
      return $signed({1'b0, QSINE[qi]});
   endfunction

endpackage

### hw/rtl/afl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module afl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/afl_csr.sv
// Configuration registers of the audio flanger.
module afl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [afl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [afl_pkg::CSR_DATA_W-1:0]      csr_data,
   output afl_pkg::afl_cfg_type                cfg
);
   import afl_pkg::*;

   afl_cfg_type cfg_ff;
   afl_cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LINE_LENGTH: cfg_in.line_length = csr_data[LEN_CFG_W-1:0];
            CSR_TAP_OFFSET:  cfg_in.tap_offset  = csr_data[OFFSET_W-1:0];
            CSR_MOD_DEPTH:   cfg_in.mod_depth   = csr_data[DEPTH_W-1:0];
            CSR_PHASE_STEP:  cfg_in.phase_step  = csr_data[PHASE_W-1:0];
            CSR_BYPASS:      cfg_in.bypass      = csr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_length <= LINE_LENGTH_RST;
         cfg_ff.tap_offset  <= '0;
         cfg_ff.mod_depth   <= '0;
         cfg_ff.phase_step  <= '0;
         cfg_ff.bypass      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/afl_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module afl_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  afl_pkg::afl_status_type status,
   output afl_pkg::afl_ctrl_type   ctrl
);
   import afl_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [STEP_W-1:0] step_inc;

   assign ctrl     = afl_ucode(step_ff);
   assign step_inc = step_ff + STEP_W'(1);

   always_comb begin
      unique case (ctrl.cond)
         COND_NONE:     step_in = step_inc;
         COND_ALWAYS:   step_in = ctrl.target;
         COND_NO_REQ:   step_in = status.req_fire ? step_inc : ctrl.target;
         COND_BYPASS:   step_in = status.bypass ? ctrl.target : step_inc;
         COND_DIV_MORE: step_in = status.div_more ? ctrl.target : step_inc;
         COND_CLR_MORE: step_in = status.clr_more ? ctrl.target : step_inc;
         COND_OUT_BUSY: step_in = status.out_busy ? step_ff : ctrl.target;
         default:       step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CLR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### hw/rtl/afl_dp.sv
// Flanger datapath: delay line, shared multiplier, remainder unit, output register.
module afl_dp #(
   parameter int LINE_ENTRIES = afl_pkg::LINE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  afl_pkg::afl_cfg_type            cfg,
   input  afl_pkg::afl_ctrl_type           ctrl,
   output afl_pkg::afl_status_type         status,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [afl_pkg::SAMPLE_W-1:0]    req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [afl_pkg::SAMPLE_W-1:0]    rsp_tdata
);
   import afl_pkg::*;

   localparam int AW = $clog2(LINE_ENTRIES);
   localparam int LW = AW + 1;
   localparam int RW = ((AW > 12) ? AW : 12) + 2;
   localparam int MW = RW - 1;
   localparam int CW = $clog2(MW);

   // registers
   logic [AW-1:0]              wp_ff, wp_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic signed [15:0]         dry_ff, dry_in;
   logic signed [33:0]         prod_ff, prod_in;
   logic signed [16:0]         s1_ff, s1_in;
   logic signed [16:0]         sn_ff, sn_in;
   logic                       neg_ff, neg_in;
   logic [MW-1:0]              mag_ff, mag_in;
   logic [LW-1:0]              rem_ff, rem_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [AW-1:0]              near_ff, near_in;
   logic [AW-1:0]              far_ff, far_in;
   logic signed [15:0]         a_ff, a_in;
   logic signed [16:0]         diff_ff, diff_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [AW-1:0]              clr_ff, clr_in;

   // combinational
   logic [LW-1:0]              eff_len;
   logic                       req_fire;
   logic [LW-1:0]              wp_inc;
   logic [AW-1:0]              wp_next;
   logic                       ram_we;
   logic [AW-1:0]              ram_waddr;
   logic [SAMPLE_W-1:0]        ram_wdata;
   logic [AW-1:0]              ram_raddr;
   logic [SAMPLE_W-1:0]        ram_rdata;
   logic signed [15:0]         sine_lo, sine_hi;
   logic [14:0]                frac_w;
   logic [15:0]                w_lo;
   logic signed [16:0]         mul_a, mul_b;
   logic signed [33:0]         prod;
   logic signed [17:0]         sn_sum;
   logic signed [12:0]         mod_m;
   logic signed [RW-1:0]       raw;
   logic signed [RW-1:0]       raw_mag;
   logic [LW:0]                trial;
   logic [LW:0]                trial_sub;
   logic [LW-1:0]              near_inc;
   logic signed [16:0]         interp_d;
   logic signed [18:0]         total;
   logic signed [18:0]         half;
   logic                       out_busy;
   logic                       out_load;

   // effective line length: zero acts as one, capped at the memory depth
   always_comb begin
      if (cfg.line_length == '0) begin
         eff_len = LW'(1);
      end else if (32'(cfg.line_length) > 32'(LINE_ENTRIES)) begin
         eff_len = LW'(LINE_ENTRIES);
      end else begin
         eff_len = LW'(cfg.line_length);
      end
   end

   assign req_tready = ctrl.take;
   assign req_fire   = req_tvalid && ctrl.take;

   assign wp_inc  = {1'b0, wp_ff} + LW'(1);
   assign wp_next = (wp_inc >= eff_len) ? '0 : wp_inc[AW-1:0];

   // delay line
   assign ram_we    = req_fire || (ctrl.alu == ALU_CLR);
   assign ram_waddr = (ctrl.alu == ALU_CLR) ? clr_ff : wp_next;
   assign ram_wdata = (ctrl.alu == ALU_CLR) ? '0 : req_tdata;
   assign ram_raddr = ctrl.rd_far ? far_ff : near_ff;

   afl_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (LINE_ENTRIES)
   ) u_line (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // sine interpolation operands from the top phase bits
   assign sine_lo = sine_entry({1'b0, phase_ff[30:22]});
   assign sine_hi = sine_entry({1'b0, phase_ff[30:22]} + 10'd1);
   assign frac_w  = {phase_ff[21:16], 9'b0};
   assign w_lo    = 16'd32768 - {1'b0, frac_w};

   // shared multiplier
   always_comb begin
      unique case (ctrl.mul)
         MUL_SIN0: begin
            mul_a = 17'(sine_lo);
            mul_b = $signed({1'b0, w_lo});
         end
         MUL_SIN1: begin
            mul_a = 17'(sine_hi);
            mul_b = $signed({2'b0, frac_w});
         end
         MUL_DEPTH: begin
            mul_a = sn_ff;
            mul_b = $signed({6'b0, cfg.mod_depth});
         end
         MUL_INTERP: begin
            mul_a = diff_ff;
            mul_b = $signed({2'b0, phase_ff[15:1]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // tap index before reduction
   assign sn_sum  = 18'(s1_ff) + 18'(prod_ff >>> 16);
   assign mod_m   = 13'(prod_ff >>> 15);
   assign raw     = $signed({{(RW-AW){1'b0}}, wp_ff})
                  - $signed({{(RW-OFFSET_W){1'b0}}, cfg.tap_offset})
                  - RW'(mod_m);
   assign raw_mag = raw[RW-1] ? -raw : raw;

   // one remainder bit per step
   assign trial     = {rem_ff, mag_ff[MW-1]};
   assign trial_sub = trial - {1'b0, eff_len};

   assign near_inc = {1'b0, near_ff} + LW'(1);

   // output sum, halved toward zero
   assign interp_d = 17'(prod_ff >>> 15);
   assign total    = 19'(dry_ff) + 19'(a_ff) + 19'(interp_d);
   assign half     = (total + $signed({18'b0, total[18]})) >>> 1;

   assign out_busy = rsp_valid_ff && !rsp_tready;
   assign out_load = ((ctrl.alu == ALU_SUM) || (ctrl.alu == ALU_PASS)) && !out_busy;

   always_comb begin
      wp_in        = wp_ff;
      phase_in     = phase_ff;
      dry_in       = dry_ff;
      prod_in      = prod_ff;
      s1_in        = s1_ff;
      sn_in        = sn_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      near_in      = near_ff;
      far_in       = far_ff;
      a_in         = a_ff;
      diff_in      = diff_ff;
      rsp_data_in  = rsp_data_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      if (req_fire) begin
         wp_in  = wp_next;
         dry_in = $signed(req_tdata);
      end

      if (ctrl.mul != MUL_NONE) begin
         prod_in = prod;
      end

      unique case (ctrl.alu)
         ALU_CLR:  clr_in = clr_ff + AW'(1);
         ALU_S1:   s1_in = 17'(prod_ff >>> 16);
         ALU_SN:   sn_in = 17'(sn_sum <<< 1);
         ALU_RAW: begin
            neg_in = raw[RW-1];
            mag_in = raw_mag[MW-1:0];
            rem_in = '0;
            cnt_in = '0;
         end
         ALU_DIV: begin
            rem_in = trial[LW] ? trial_sub[LW-1:0] :
                     ((trial >= {1'b0, eff_len}) ? trial_sub[LW-1:0] : trial[LW-1:0]);
            mag_in = mag_ff << 1;
            cnt_in = cnt_ff + CW'(1);
         end
         ALU_NEAR: begin
            near_in = (neg_ff && (rem_ff != '0)) ? AW'(eff_len - rem_ff) : AW'(rem_ff);
         end
         ALU_FAR: begin
            if (sn_ff[16]) begin
               far_in = (near_ff == '0) ? AW'(eff_len - LW'(1)) : near_ff - AW'(1);
            end else begin
               far_in = (near_inc >= eff_len) ? '0 : near_inc[AW-1:0];
            end
         end
         ALU_LDA:  a_in = $signed(ram_rdata);
         ALU_DIFF: diff_in = 17'($signed(ram_rdata)) - 17'(a_ff);
         ALU_SUM: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               phase_in     = phase_ff + cfg.phase_step;
               if (half > 19'sd32767) begin
                  rsp_data_in = SAMPLE_POS_MAX;
               end else if (half < -19'sd32768) begin
                  rsp_data_in = SAMPLE_NEG_MAX;
               end else begin
                  rsp_data_in = half[15:0];
               end
            end
         end
         ALU_PASS: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = dry_ff;
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dry_ff      <= dry_in;
      prod_ff     <= prod_in;
      s1_ff       <= s1_in;
      sn_ff       <= sn_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      near_ff     <= near_in;
      far_ff      <= far_in;
      a_ff        <= a_in;
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.req_fire = req_fire;
   assign status.bypass   = cfg.bypass;
   assign status.div_more = (cnt_ff != CW'(MW - 1));
   assign status.clr_more = (clr_ff != AW'(LINE_ENTRIES - 1));
   assign status.out_busy = out_busy;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result register loaded while a beat is still pending");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("sequencer stayed ready after taking a beat");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (ctrl.alu == ALU_CLR) |-> !req_tready)
      else $error("input ready during delay line clear");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (ctrl.alu == ALU_DIV) |-> ({1'b0, cnt_ff} < (CW + 1)'(MW)))
      else $error("remainder step count overran");
`endif

endmodule

### hw/rtl/audio_flanger.sv
// Audio flanger top level: register file, microcode sequencer and datapath.
// After reset the delay line is cleared one entry per cycle, all LINE_ENTRIES entries
// (2048 by default), with req_tready low; configuration writes are taken meanwhile.
// Flanged sample: the result is registered after the tap index is wrapped by the
// bit-per-cycle remainder over MW = max(log2(LINE_ENTRIES), 12) + 1 bits; a new
// input beat is taken only once the result of the last one is registered.
// Bypass: the input beat is registered as the result unchanged, with the same rule.
module audio_flanger #(
   parameter int LINE_ENTRIES = afl_pkg::LINE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input stream, tdata: sample_in[15:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [afl_pkg::SAMPLE_W-1:0]      req_tdata,
   // result stream, tdata: sample_out[15:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [afl_pkg::SAMPLE_W-1:0]      rsp_tdata,
   // register writes: 0 line_length, 1 tap_offset, 2 mod_depth, 3 phase_step, 4 bypass
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [afl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [afl_pkg::CSR_DATA_W-1:0]    csr_data
);
   import afl_pkg::*;

   afl_cfg_type    cfg;
   afl_ctrl_type   ctrl;
   afl_status_type status;

   // hold the configuration; unknown indexes are dropped
   afl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // step through the control store: clear, wait for a beat, sine, tap
   // reduction, two line reads, interpolation, then output; bypass skips to output
   afl_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // the datapath stores each sample at the advanced write index on accept,
   // then executes one control word per cycle
   afl_dp #(
      .LINE_ENTRIES (LINE_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .ctrl       (ctrl),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
